// ===== hdl/tea_pkg.sv =====
// shared types, constants and round function for the tea block cipher
package tea_pkg;

	localparam int WORD_W    = 32;
	localparam int ROUNDS    = 32;
	localparam int STAGES    = 2 * ROUNDS;
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2,
		REG_KEY3 = 2'd3
	} cfg_reg_t;

	localparam word_t DELTA = 32'h9E37_79B9;

	// round sum constant, wraps modulo 2^32
	function automatic word_t delta_mul(input int n);
		logic [2*WORD_W-1:0] p;
		p = (2*WORD_W)'(DELTA) * (2*WORD_W)'(n);
		return p[WORD_W-1:0];
	endfunction

	function automatic word_t mix(input word_t x, input word_t s, input word_t ka,
			input word_t kb);
		return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
	endfunction

endpackage

// ===== hdl/tea_block_cipher_top.sv =====
// tea block cipher, one half round per pipeline stage
//
//  channel  signals                                   direction
//  in       in_valid/in_ready, cmd, data_left/right   transfer into block
//  out      out_valid/out_ready, result_left/right    transfer out of block
//  cfg      cfg_we, cfg_index, cfg_data               key word write, no wait
//
// one block enters per cycle while the skid register is empty; one stage per half round
// a one-entry skid register behind the last stage holds a result the sink refuses
// the pipeline stalls only while that skid register is full; nothing is lost or repeated
// arst_n clears valid bits, skid state and key words (keys reset to zero)
module tea_block_cipher_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  tea_pkg::word_t   data_left,
	input  tea_pkg::word_t   data_right,
	output logic             out_valid,
	input  logic             out_ready,
	output tea_pkg::word_t   result_left,
	output tea_pkg::word_t   result_right,
	input  logic             cfg_we,
	input  tea_pkg::cfg_idx_t cfg_index,
	input  tea_pkg::word_t   cfg_data
);
	import tea_pkg::*;

	localparam int LAST = STAGES - 1;

	word_t key_q [KEY_WORDS];

	logic  valid_s [STAGES];
	logic  cmd_s   [STAGES];
	word_t left_s  [STAGES];
	word_t right_s [STAGES];

	logic  skid_valid_q;
	word_t skid_left_q;
	word_t skid_right_q;
	logic  adv;

	assign adv      = !skid_valid_q;
	assign in_ready = adv;

	// key words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
			endcase
		end
	end

	for (genvar g = 0; g < STAGES; g++) begin : stage
		localparam word_t SUM_ENC = delta_mul(g / 2 + 1);
		localparam word_t SUM_DEC = delta_mul(ROUNDS - g / 2);
		localparam logic  ODD     = 1'(g % 2);

		logic  v_in;
		logic  c_in;
		word_t l_in;
		word_t r_in;
		logic  upd_left;
		word_t x;
		word_t ka;
		word_t kb;
		word_t s;
		word_t m;
		word_t tgt;
		word_t nt;

		if (g == 0) begin : from_port
			assign v_in = in_valid;
			assign c_in = cmd;
			assign l_in = data_left;
			assign r_in = data_right;
		end else begin : from_stage
			assign v_in = valid_s[g-1];
			assign c_in = cmd_s[g-1];
			assign l_in = left_s[g-1];
			assign r_in = right_s[g-1];
		end

		// encrypt updates left on even stages, decrypt on odd stages
		always_comb begin
			upd_left = (c_in == ODD);
			x        = upd_left ? r_in : l_in;
			ka       = upd_left ? key_q[0] : key_q[2];
			kb       = upd_left ? key_q[1] : key_q[3];
			s        = c_in ? SUM_DEC : SUM_ENC;
			m        = mix(x, s, ka, kb);
			tgt      = upd_left ? l_in : r_in;
			nt       = c_in ? (tgt - m) : (tgt + m);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (adv) begin
				valid_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv && v_in) begin
				cmd_s[g]   <= c_in;
				left_s[g]  <= upd_left ? nt : l_in;
				right_s[g] <= upd_left ? r_in : nt;
			end
		end
	end

	// skid register behind the last stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (adv && valid_s[LAST] && !out_ready) begin
			skid_valid_q <= 1'b1;
		end else if (skid_valid_q && out_ready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s[LAST]) begin
			skid_left_q  <= left_s[LAST];
			skid_right_q <= right_s[LAST];
		end
	end

	assign out_valid    = skid_valid_q | valid_s[LAST];
	assign result_left  = skid_valid_q ? skid_left_q : left_s[LAST];
	assign result_right = skid_valid_q ? skid_right_q : right_s[LAST];

endmodule

// ===== hdl/tea_chk.sv =====
// port checker for the tea block cipher, bound to the top level
module tea_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input tea_pkg::word_t    result_left,
	input tea_pkg::word_t    result_right
);
	import tea_pkg::*;

	localparam int CNT_W = $clog2(STAGES + 2) + 1;

	logic [CNT_W-1:0] inflight_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = in_valid & in_ready;
	assign out_xfer = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
		end
	end

	// refused result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_left)
			&& $stable(result_right))
		else $error("refused result changed or dropped");

	// input stalls only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// no result without a block in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result with no block in flight");

	// occupancy bounded by pipeline depth plus skid
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(STAGES + 1))
		else $error("more blocks in flight than storage");

endmodule

bind tea_block_cipher_top tea_chk u_chk (.*);

// ===== tb/sv/tea_block_cipher_top_test.sv =====
// self-checking testbench for the tea block cipher: random and directed blocks under several keys
`timescale 1ns / 100ps

module tea_block_cipher_top_test;
	import tea_pkg::*;

	localparam int   CLK_HALF        = 10;
	localparam int   PHASES          = 7;
	localparam int   BLOCKS_PER_KEY  = 232;
	localparam int   LONG_HOLD       = 300;
	localparam int   FLUSH_CYCLES    = 2 * ROUNDS + 8;
	localparam int   CYCLE_LIMIT     = 200000;
	localparam int   MAX_PRINTED     = 100;
	localparam logic CMD_ENCRYPT     = 1'b0;
	localparam logic CMD_DECRYPT     = 1'b1;
	localparam word_t GOLDEN         = 32'h9E37_79B9;

	typedef struct packed {
		word_t left;
		word_t right;
	} block_t;

	class tea_block_scoreboard;
		word_t  key[KEY_WORDS];
		block_t pending_q[$];
		int     errors;

		function new();
			foreach (key[i]) key[i] = '0;
			errors = 0;
		endfunction

		function void set_key(cfg_reg_t idx, word_t value);
			key[idx] = value;
		endfunction

		function word_t feistel(word_t x, word_t sum, word_t ka, word_t kb);
			return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
		endfunction

		function block_t cipher(logic op, word_t l, word_t r);
			word_t sum;
			if (op == CMD_ENCRYPT) begin
				sum = '0;
				repeat (ROUNDS) begin
					sum += GOLDEN;
					l += feistel(r, sum, key[REG_KEY0], key[REG_KEY1]);
					r += feistel(l, sum, key[REG_KEY2], key[REG_KEY3]);
				end
			end else begin
				sum = word_t'(GOLDEN * ROUNDS);
				repeat (ROUNDS) begin
					r -= feistel(l, sum, key[REG_KEY2], key[REG_KEY3]);
					l -= feistel(r, sum, key[REG_KEY0], key[REG_KEY1]);
					sum -= GOLDEN;
				end
			end
			return '{left: l, right: r};
		endfunction

		function void note_block(logic op, word_t l, word_t r);
			pending_q.push_back(cipher(op, l, r));
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_block(word_t l, word_t r);
			block_t want;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result %h %h with no block outstanding", l, r));
				return;
			end
			want = pending_q.pop_front();
			if (l !== want.left)
				report_mismatch($sformatf("result_left %h, expected %h", l, want.left));
			if (r !== want.right)
				report_mismatch($sformatf("result_right %h, expected %h", r, want.right));
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	logic     cmd = CMD_ENCRYPT;
	word_t    data_left = '0;
	word_t    data_right = '0;
	logic     out_valid;
	logic     out_ready = 1'b1;
	word_t    result_left;
	word_t    result_right;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_index = '0;
	word_t    cfg_data = '0;

	tea_block_scoreboard sb = new();
	bit sender_gaps = 1'b1;
	int cycle_count = 0;

	tea_block_cipher_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.data_left    (data_left),
		.data_right   (data_right),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_left  (result_left),
		.result_right (result_right),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// sink side: random stalls per transfer, quiet stretches, and a long hold now and then
	initial begin
		int taken;
		int stall;
		taken = 0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_block(result_left, result_right);
				taken++;
				if (taken % 250 == 100)
					stall = LONG_HOLD;
				else if ((taken / 150) % 3 != 2)
					stall = $urandom_range(0, 3);
				else
					stall = 0;
				if (stall > 0)
					out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				if (stall == 0)
					out_ready <= 1'b1;
			end
		end
	end

	task automatic send_block(input logic op, input word_t l, input word_t r);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		data_left  <= l;
		data_right <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_block(op, l, r);
	endtask

	task automatic load_key(input word_t k0, input word_t k1, input word_t k2,
			input word_t k3);
		cfg_reg_t regs[KEY_WORDS] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};
		word_t    words[KEY_WORDS];
		words = '{k0, k1, k2, k3};
		for (int i = 0; i < KEY_WORDS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= words[i];
			@(posedge clk);
			sb.set_key(regs[i], words[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 11))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// an encryption followed by the decryption of its ciphertext, or the other way round
	task automatic send_round_trip();
		logic   op;
		word_t  l;
		word_t  r;
		block_t mid;
		op  = 1'($urandom_range(0, 1));
		l   = pick_word();
		r   = pick_word();
		send_block(op, l, r);
		mid = sb.cipher(op, l, r);
		send_block(op == CMD_ENCRYPT ? CMD_DECRYPT : CMD_ENCRYPT, mid.left, mid.right);
	endtask

	initial begin
		word_t edge_l[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h5555_5555};
		word_t edge_r[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0000_0001, 32'hAAAA_AAAA};
		int sent;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			sender_gaps = (ph % 3 != 1);
			case (ph)
				0: ;
				1: load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
				3: load_key(32'h8000_0000, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
				default: load_key($urandom, $urandom, $urandom, $urandom);
			endcase

			if (ph == 0) begin
				foreach (edge_l[i]) begin
					send_block(CMD_ENCRYPT, edge_l[i], edge_r[i]);
					send_block(CMD_DECRYPT, edge_l[i], edge_r[i]);
				end
				send_round_trip();
			end else if (ph == 1) begin
				for (int i = 0; i < 2; i++) begin
					send_block(CMD_ENCRYPT, edge_l[i], edge_r[i]);
					send_block(CMD_DECRYPT, edge_l[i], edge_r[i]);
				end
			end

			sent = 0;
			while (sent < BLOCKS_PER_KEY) begin
				if ($urandom_range(0, 3) == 0) begin
					send_round_trip();
					sent += 2;
				end else begin
					send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
					sent++;
				end
			end
			wait_drained();
		end

		repeat (FLUSH_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tea_pkg.sv
hdl/tea_block_cipher_top.sv
hdl/tea_chk.sv
tb/sv/tea_block_cipher_top_test.sv
